// File: hdl/ppu_pkg.sv
`timescale 1ns / 1ps
package ppu_pkg;

  localparam int PP_MAX   = 64;
  localparam int ADDR_W   = 6;
  localparam int DEPTH    = 64;
  localparam int CNT_W    = 7;
  localparam int LANES    = 5;
  localparam int LANE_W   = 3;
  localparam int DIV_STEP = 16;

  typedef struct packed {
    logic        func;
    logic [15:0] life;
    logic [47:0] start_position;
    logic [47:0] start_velocity;
    logic [47:0] acceleration;
    logic [15:0] first_scale;
    logic [15:0] final_scale;
    logic [31:0] first_color;
    logic [31:0] final_color;
  } in_t;

  typedef struct packed {
    logic [47:0] out_position;
    logic [15:0] out_scale;
    logic [31:0] out_color;
    logic        last;
  } out_t;

  // one pool entry as kept in the record memory
  typedef struct packed {
    logic [47:0] pos;
    logic [47:0] vel;
    logic [47:0] acc;
    logic [15:0] life;
    logic [15:0] age;
    logic [31:0] scale_pair;
    logic [63:0] color_pair;
  } rec_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    logic tick;
  } q_ctl_t;

  // back end status for checks
  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] live_cnt;
  } stat_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? 16'h8000 : 16'h7fff;
    end
    return s[15:0];
  endfunction

  function automatic logic [47:0] sat_add_vec(input logic [47:0] a, input logic [47:0] b);
    logic [47:0] r;
    for (int k = 0; k < 3; k++) begin
      r[16*k +: 16] = sat_add16(a[16*k +: 16], b[16*k +: 16]);
    end
    return r;
  endfunction

endpackage

// File: hdl/ppu_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle; needs dividend < divisor * 2^16
module ppu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import ppu_pkg::*;

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] sh_r, sh_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [16:0] trial;

  assign trial    = {rem_r, sh_r[15]};
  assign done     = run_r && (cnt_r == 5'(DIV_STEP - 1));
  assign quotient = sh_r;

  // one shift and subtract step
  always_comb begin
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (go) begin
      rem_nxt = dividend[31:16];
      sh_nxt  = dividend[15:0];
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = 16'(trial - {1'b0, divisor});
        sh_nxt  = {sh_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        sh_nxt  = {sh_r[14:0], 1'b0};
      end
      cnt_nxt = 5'(cnt_r + 5'd1);
      if (done) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

endmodule

// File: hdl/ppu_front.sv
`timescale 1ns / 1ps
// accepts items into a two-entry queue and tags each as add or tick
module ppu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ppu_pkg::in_t    in_item,
  input  logic            pop,
  output ppu_pkg::q_ctl_t q_ctl,
  output ppu_pkg::in_t    q_item
);
  import ppu_pkg::*;

  in_t        q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       push, do_pop;

  assign busy       = (fill_r == 2'd2);
  assign push       = start && !busy;
  assign do_pop     = pop && (fill_r != 2'd0);
  assign q_ctl.valid = (fill_r != 2'd0);
  assign q_ctl.tick  = q_item.func;
  assign q_item      = q_mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= 2'(fill_r + {1'b0, push} - {1'b0, do_pop});
    end
  end

endmodule

// File: hdl/ppu_back.sv
`timescale 1ns / 1ps
// carries out adds and ticks on the circular record memory
module ppu_back #(
  parameter int MAX_PARTICLES = ppu_pkg::PP_MAX
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ppu_pkg::q_ctl_t q_ctl,
  input  ppu_pkg::in_t    q_item,
  output logic            pop,
  output logic            out_valid,
  output ppu_pkg::out_t   out_item,
  output ppu_pkg::stat_t  stat
);
  import ppu_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_POS   = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_DGO   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_ENDT  = 9'b100000000
  } state_t;

  localparam logic [LANE_W-1:0] LANE_SCALE = 3'd0;
  localparam logic [LANE_W-1:0] LANE_R     = 3'd1;
  localparam logic [LANE_W-1:0] LANE_G     = 3'd2;
  localparam logic [LANE_W-1:0] LANE_B     = 3'd3;
  localparam logic [LANE_W-1:0] LANE_A     = 3'd4;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  wr_n_r, wr_n_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  rec_t              rdata_r;
  rec_t              w_r, w_nxt;
  out_t              pend_r, pend_nxt;
  logic              have_pend_r, have_pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  rec_t              mem [DEPTH];
  logic              we;
  logic [ADDR_W-1:0] wa;
  rec_t              wd;

  logic [31:0]       dvd_r [LANES];
  logic              neg_r [LANES];
  logic [15:0]       st_r  [LANES];
  logic [15:0]       quo   [LANES];
  logic              ddone [LANES];
  logic [15:0]       res   [LANES];

  logic [15:0]       ls, le, mag;
  logic [16:0]       diff;
  logic [31:0]       prod;
  rec_t              new_rec;

  assign pop       = (state_r == S_IDLE) && q_ctl.valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign stat.idle     = (state_r == S_IDLE);
  assign stat.live_cnt = cnt_r;

  // record memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr_r];
  end

  // operands of the current lerp lane
  always_comb begin
    case (lane_r)
      LANE_SCALE: begin
        ls = w_r.scale_pair[15:0];
        le = w_r.scale_pair[31:16];
      end
      LANE_R: begin
        ls = {8'd0, w_r.color_pair[7:0]};
        le = {8'd0, w_r.color_pair[39:32]};
      end
      LANE_G: begin
        ls = {8'd0, w_r.color_pair[15:8]};
        le = {8'd0, w_r.color_pair[47:40]};
      end
      LANE_B: begin
        ls = {8'd0, w_r.color_pair[23:16]};
        le = {8'd0, w_r.color_pair[55:48]};
      end
      LANE_A: begin
        ls = {8'd0, w_r.color_pair[31:24]};
        le = {8'd0, w_r.color_pair[63:56]};
      end
      default: begin
        ls = '0;
        le = '0;
      end
    endcase
    diff = {1'b0, le} - {1'b0, ls};
    mag  = diff[16] ? 16'(-diff) : diff[15:0];
    prod = mag * w_r.age;
  end

  // lerp lanes share the divisor
  for (genvar g = 0; g < LANES; g++) begin : g_div
    ppu_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .go       (state_r == S_DGO),
      .dividend (dvd_r[g]),
      .divisor  (w_r.life),
      .done     (ddone[g]),
      .quotient (quo[g])
    );
    assign res[g] = neg_r[g] ? 16'(st_r[g] - quo[g]) : 16'(st_r[g] + quo[g]);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      dvd_r[lane_r] <= prod;
      neg_r[lane_r] <= diff[16];
      st_r[lane_r]  <= ls;
    end
  end

  // new particle record from the queue head
  always_comb begin
    new_rec.pos        = q_item.start_position;
    new_rec.vel        = q_item.start_velocity;
    new_rec.acc        = q_item.acceleration;
    new_rec.life       = q_item.life;
    new_rec.age        = '0;
    new_rec.scale_pair = {q_item.final_scale, q_item.first_scale};
    new_rec.color_pair = {q_item.final_color, q_item.first_color};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    wr_n_nxt      = wr_n_r;
    rd_addr_nxt   = rd_addr_r;
    lane_nxt      = lane_r;
    w_nxt         = w_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    wa            = '0;
    wd            = w_r;
    case (state_r)
      S_IDLE: begin
        if (q_ctl.valid) begin
          if (!q_ctl.tick) begin
            if (cnt_r != CNT_W'(MAX_PARTICLES)) begin
              base_nxt = ADDR_W'(base_r - 1'b1);
              we       = 1'b1;
              wa       = ADDR_W'(base_r - 1'b1);
              wd       = new_rec;
              cnt_nxt  = CNT_W'(cnt_r + 1'b1);
            end
          end else if (cnt_r != '0) begin
            idx_nxt       = '0;
            wr_n_nxt      = '0;
            have_pend_nxt = 1'b0;
            rd_addr_nxt   = base_r;
            state_nxt     = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (rdata_r.age >= rdata_r.life) begin
          // expired, drop it
          idx_nxt = CNT_W'(idx_r + 1'b1);
          if (CNT_W'(idx_r + 1'b1) == cnt_r) begin
            state_nxt = S_ENDT;
          end else begin
            rd_addr_nxt = ADDR_W'(base_r + idx_r[ADDR_W-1:0] + 1'b1);
            state_nxt   = S_READ;
          end
        end else begin
          w_nxt     = rdata_r;
          w_nxt.age = 16'(rdata_r.age + 1'b1);
          w_nxt.vel = sat_add_vec(rdata_r.vel, rdata_r.acc);
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        w_nxt.pos = sat_add_vec(w_r.pos, w_r.vel);
        lane_nxt  = LANE_SCALE;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        lane_nxt = LANE_W'(lane_r + 1'b1);
        if (lane_r == LANE_A) begin
          state_nxt = S_DGO;
        end
      end
      S_DGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (ddone[0]) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // write back compacted, pass on the previous survivor
        we = 1'b1;
        wa = ADDR_W'(base_r + wr_n_r[ADDR_W-1:0]);
        wd = w_r;
        if (have_pend_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b0;
        end
        pend_nxt.out_position = w_r.pos;
        pend_nxt.out_scale    = res[LANE_SCALE];
        pend_nxt.out_color    = {res[LANE_A][7:0], res[LANE_B][7:0],
                                 res[LANE_G][7:0], res[LANE_R][7:0]};
        pend_nxt.last         = 1'b0;
        have_pend_nxt         = 1'b1;
        wr_n_nxt = CNT_W'(wr_n_r + 1'b1);
        idx_nxt  = CNT_W'(idx_r + 1'b1);
        if (CNT_W'(idx_r + 1'b1) == cnt_r) begin
          state_nxt = S_ENDT;
        end else begin
          rd_addr_nxt = ADDR_W'(base_r + idx_r[ADDR_W-1:0] + 1'b1);
          state_nxt   = S_READ;
        end
      end
      S_ENDT: begin
        if (have_pend_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
        end
        have_pend_nxt = 1'b0;
        cnt_nxt       = wr_n_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    wr_n_r    <= wr_n_nxt;
    rd_addr_r <= rd_addr_nxt;
    lane_r    <= lane_nxt;
    w_r       <= w_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      cnt_r       <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/particle_pool_update.sv
`timescale 1ns / 1ps
// add: written straight from the queue head, no result; dropped while the pool is full.
// tick: each survivor is read, checked, moved, lerped (16-step divider) and written back,
//   an expired one only read and checked; the final result of a tick is flagged last.
// items queue two deep; busy is high while the queue is full. results cannot be stalled.
// reset (synchronous, rst_n low) empties the pool; record memory is not cleared.
module particle_pool_update #(
  parameter int MAX_PARTICLES = ppu_pkg::PP_MAX
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ppu_pkg::in_t  in_item,
  output logic          out_valid,
  output ppu_pkg::out_t out_item
);
  import ppu_pkg::*;

  q_ctl_t q_ctl;
  in_t    q_item;
  logic   pop;
  stat_t  stat;

  ppu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .q_ctl   (q_ctl),
    .q_item  (q_item)
  );

  ppu_back #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (q_ctl),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  // pool never overfills
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    stat.live_cnt <= CNT_W'(MAX_PARTICLES))
    else $error("live count above pool size");

  // results only come out of a tick in progress
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(!stat.idle))
    else $error("result while back end idle");

  // the last result ends the tick
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("result right after last");
`endif

endmodule
